[rtl/mrr_pkg.sv]
`default_nettype none

package mrr_pkg;

  localparam int MAX_ROWS   = 8;
  localparam int MAX_COLS   = 8;
  localparam int DEPTH      = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int TOTAL_W    = ADDR_W + 1;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int SIZE_W     = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int DATA_W     = 32;
  localparam int RESET_SIZE = 8;

  typedef logic [SIZE_W-1:0]        size_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [TOTAL_W-1:0]       total_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
  typedef logic [ROW_W-1:0]         row_t;
  typedef logic [COL_W-1:0]         col_t;

  localparam cfg_idx_t REG_ROWS_IN_USE = CFG_IDX_W'(0);
  localparam cfg_idx_t REG_COLS_IN_USE = CFG_IDX_W'(1);

  typedef struct packed {
    row_t row;
    col_t col;
  } pos_t;

  typedef struct packed {
    size_t rows;
    size_t cols;
  } geom_t;

  typedef enum logic [1:0] {
    PH_LOAD = 2'b01,
    PH_EMIT = 2'b10
  } phase_t;

  // Zero counts as one, anything above the maximum saturates.
  function automatic size_t clamp_size(size_t v, size_t maxv);
    size_t r;
    if (v == SIZE_W'(0)) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/mrr_if.sv]
`default_nettype none

interface mrr_in_if;
  import mrr_pkg::*;
  logic  valid;
  logic  ready;
  data_t element_value;
  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

interface mrr_out_if;
  import mrr_pkg::*;
  logic  valid;
  logic  ready;
  data_t rotated_value;
  logic  last_of_matrix;
  modport source (output valid, output rotated_value, output last_of_matrix, input ready);
  modport sink (input valid, input rotated_value, input last_of_matrix, output ready);
endinterface

interface mrr_cfg_if;
  import mrr_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  size_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/mrr_source_map.sv]
`default_nettype none

module mrr_source_map (
  input  mrr_pkg::pos_t  pos,
  input  mrr_pkg::geom_t geom,
  output mrr_pkg::addr_t src_addr
);
  import mrr_pkg::*;

  row_t               last_row;
  col_t               last_col;
  row_t               dist_bottom;
  col_t               dist_right;
  logic [ROW_W-1:0]   ring_r;
  logic [COL_W-1:0]   ring_c;
  logic [SIZE_W:0]    ring;
  logic               rotated;
  row_t               ring_bottom;
  col_t               ring_right;
  row_t               src_row;
  col_t               src_col;
  logic [TOTAL_W-1:0] addr_wide;

  always_comb begin
    last_row    = ROW_W'(geom.rows - SIZE_W'(1));
    last_col    = COL_W'(geom.cols - SIZE_W'(1));
    dist_bottom = last_row - pos.row;
    dist_right  = last_col - pos.col;
    ring_r      = (pos.row < dist_bottom) ? pos.row : dist_bottom;
    ring_c      = (pos.col < dist_right) ? pos.col : dist_right;
    // Ring depth is the distance to the nearest edge.
    if ((SIZE_W + 1)'(ring_r) < (SIZE_W + 1)'(ring_c)) begin
      ring = (SIZE_W + 1)'(ring_r);
    end else begin
      ring = (SIZE_W + 1)'(ring_c);
    end
    // A ring moves only while it still has at least two rows and two columns.
    rotated = ((ring << 1) + (SIZE_W + 1)'(2) <= (SIZE_W + 1)'(geom.rows)) &&
              ((ring << 1) + (SIZE_W + 1)'(2) <= (SIZE_W + 1)'(geom.cols));
    ring_bottom = last_row - ROW_W'(ring);
    ring_right  = last_col - COL_W'(ring);

    src_row = pos.row;
    src_col = pos.col;
    if (rotated) begin
      if (pos.row == ROW_W'(ring)) begin
        if (pos.col == COL_W'(ring)) begin
          src_row = pos.row + ROW_W'(1);
        end else begin
          src_col = pos.col - COL_W'(1);
        end
      end else if (pos.col == ring_right) begin
        src_row = pos.row - ROW_W'(1);
      end else if (pos.row == ring_bottom) begin
        src_col = pos.col + COL_W'(1);
      end else begin
        src_row = pos.row + ROW_W'(1);
      end
    end
    addr_wide = TOTAL_W'(src_row) * TOTAL_W'(geom.cols) + TOTAL_W'(src_col);
    src_addr  = addr_wide[ADDR_W-1:0];
  end

endmodule

`default_nettype wire

[rtl/matrix_ring_rotate_by_one.sv]
`default_nettype none

// Loads a rows_in_use by cols_in_use matrix of signed 32-bit elements, one beat
// per element in row-major order, into a 64-entry single-port-read store, and
// once the last element has arrived streams the matrix back out in row-major
// order with every ring of at least two rows and two columns moved one place
// clockwise; the final beat carries last_of_matrix. Emission reads one store
// entry per cycle through the single read port while the sink is ready. After
// the last input beat the block enters its emit phase, and each result then
// passes through the registered store read and the output register. Input is
// held off while a matrix is being read out; results stall cleanly under
// backpressure. Register 0 sets rows, register 1 sets columns (zero reads as
// one, values above eight saturate); write them only while the block is idle.
module matrix_ring_rotate_by_one (
  input  logic        clk,
  input  logic        rst,
  mrr_in_if.sink      elements,
  mrr_out_if.source   results,
  mrr_cfg_if.sink     cfg
);
  import mrr_pkg::*;

  // Element store; read data is registered.
  data_t  element_store [DEPTH];
  data_t  rdata;

  size_t  rows_reg;
  size_t  cols_reg;
  geom_t  geom;
  total_t total;

  phase_t phase;
  addr_t  load_count;
  logic   load_done;
  logic   in_beat;

  pos_t   pos;
  logic   last_pos;
  logic   issue;
  addr_t  src_addr;

  // Read stage: rdata holds a fetched element waiting for the output register.
  logic   a_valid;
  logic   a_last;
  logic   a_move;

  logic   out_valid;
  data_t  out_data;
  logic   out_last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_reg <= SIZE_W'(RESET_SIZE);
      cols_reg <= SIZE_W'(RESET_SIZE);
    end else if (cfg.valid) begin
      if (cfg.index == REG_ROWS_IN_USE) begin
        rows_reg <= cfg.data;
      end else if (cfg.index == REG_COLS_IN_USE) begin
        cols_reg <= cfg.data;
      end
    end
  end

  always_comb begin
    geom.rows = clamp_size(rows_reg, SIZE_W'(MAX_ROWS));
    geom.cols = clamp_size(cols_reg, SIZE_W'(MAX_COLS));
    total     = TOTAL_W'(geom.rows) * TOTAL_W'(geom.cols);
  end

  // The store accepts new elements only while no matrix is being read out.
  assign elements.ready = (phase == PH_LOAD);
  assign in_beat        = elements.valid && elements.ready;
  // A size change during a load can leave the count at or past the new total;
  // the next element then completes the load.
  assign load_done      = (TOTAL_W'(load_count) + TOTAL_W'(1)) >= total;

  mrr_source_map u_map (
    .pos      (pos),
    .geom     (geom),
    .src_addr (src_addr)
  );

  assign last_pos = (pos.row == ROW_W'(geom.rows - SIZE_W'(1))) &&
                    (pos.col == COL_W'(geom.cols - SIZE_W'(1)));
  assign a_move   = a_valid && (!out_valid || results.ready);
  assign issue    = (phase == PH_EMIT) && (!a_valid || a_move);

  always_ff @(posedge clk) begin
    if (in_beat) begin
      element_store[load_count] <= elements.element_value;
    end
    if (issue) begin
      rdata  <= element_store[src_addr];
      a_last <= last_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LOAD;
      load_count <= '0;
      pos        <= '0;
    end else begin
      unique case (phase)
        PH_LOAD: begin
          if (in_beat) begin
            if (load_done) begin
              load_count <= '0;
              pos        <= '0;
              phase      <= PH_EMIT;
            end else begin
              load_count <= load_count + ADDR_W'(1);
            end
          end
        end
        PH_EMIT: begin
          if (issue) begin
            if (last_pos) begin
              phase <= PH_LOAD;
            end
            if (pos.col == COL_W'(geom.cols - SIZE_W'(1))) begin
              pos.col <= '0;
              pos.row <= pos.row + ROW_W'(1);
            end else begin
              pos.col <= pos.col + COL_W'(1);
            end
          end
        end
        default: begin
          phase <= PH_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        a_valid <= 1'b1;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
      if (a_move) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      out_data <= rdata;
      out_last <= a_last;
    end
  end

  assign results.valid          = out_valid;
  assign results.rotated_value  = out_data;
  assign results.last_of_matrix = out_last;

endmodule

`default_nettype wire
